/* hw/rtl/smma_pkg.sv */
// Shared types and constants for the second moment matrix accumulator.
// Holds the result width, register indexes, divider status and saturating add.
// No dependencies.
`default_nettype none

package smma_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 48;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned NV_W    = 3;
  localparam int unsigned CFG_A_W = 1;
  localparam int unsigned CFG_D_W = 3;

  // Default sizing of the top level
  localparam int unsigned MAX_VARS_DEF    = 7;
  localparam int unsigned MAX_OBS_DEF     = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_ADD_CONST = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_NUM_VARS  = 1'b1;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Add two signed values and clamp to the signed result range
  function automatic logic signed [VALUE_W-1:0] sat_add(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    logic signed [VALUE_W:0] s;
    logic signed [VALUE_W-1:0] r;
    s = (VALUE_W+1)'(a) + (VALUE_W+1)'(b);
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      r = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      r = s[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/smma_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Quotient truncates toward zero. Depends on smma_pkg.
`default_nettype none

module smma_div #(
  parameter int unsigned CNT_W = 17
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [smma_pkg::VALUE_W-1:0] dividend_i,
  input  wire logic        [CNT_W-1:0]             divisor_i,
  output logic signed      [smma_pkg::VALUE_W-1:0] quotient_o,
  output smma_pkg::div_status_t                    status_o
);

  localparam int unsigned VW     = smma_pkg::VALUE_W;
  localparam int unsigned STEP_W = $clog2(VW + 1);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic [VW-1:0]     quo_q;
  logic [CNT_W:0]    rem_q;
  logic [CNT_W:0]    trial;
  logic              ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_q[CNT_W-1:0], quo_q[VW-1]};
    ge    = trial >= {1'b0, divisor_i};
  end

  // Restoring division on the magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(VW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[VW-1];
      quo_q <= dividend_i[VW-1] ? (VW'(0) - dividend_i) : dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[VW-2:0], ge};
      rem_q <= ge ? (trial - {1'b0, divisor_i}) : trial;
    end
  end

  // Restore the sign
  assign quotient_o = neg_q ? (VW'(0) - quo_q) : quo_q;

  always_comb begin
    status_o.busy = busy_q;
    status_o.done = done_q;
  end

endmodule

`default_nettype wire

/* hw/rtl/second_moment_matrix_accumulator.sv */
// Second moment matrix accumulator: sums of pairwise products, column sums and
// an observation count, emitted as the mean product matrix. Uses smma_pkg, smma_div.
//
//   channel | signals                                           | dir
//   in      | in_valid_i/in_ready_o, sample_i, var_index_i,     | in
//           | end_of_set_i                                      |
//   out     | out_valid_o/out_ready_i, row_o, col_o, value_o,   | out
//           | no_data_o, last_o                                 |
//   cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i  | in
//
// A completing sample sends one shared multiplier and 48-bit saturating adders
// over the upper triangle: a column sum in S_ACC_A, then S_ACC_M and S_ACC_S per
// product. End of set emits size*size items; the means come from the bit-serial
// divider. Reset clears all sums at once; no clearing pass.
// in_ready_o is low while a sample or a matrix is in work; a stalled out_ready_i
// holds the sequencer only when the next item is ready to load.
`default_nettype none

module second_moment_matrix_accumulator #(
  parameter int unsigned MAX_VARS    = smma_pkg::MAX_VARS_DEF,
  parameter int unsigned MAX_OBS     = smma_pkg::MAX_OBS_DEF,
  parameter int unsigned SAMPLE_BITS = smma_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input samples
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  wire logic        [smma_pkg::NV_W-1:0]    var_index_i,
  input  wire logic                                end_of_set_i,
  // matrix entries
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic        [smma_pkg::POS_W-1:0]        row_o,
  output logic        [smma_pkg::POS_W-1:0]        col_o,
  output logic signed [smma_pkg::VALUE_W-1:0]      value_o,
  output logic                                     no_data_o,
  output logic                                     last_o,
  // configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [smma_pkg::CFG_A_W-1:0]        cfg_index_i,
  input  wire logic [smma_pkg::CFG_D_W-1:0]        cfg_data_i
);

  localparam int unsigned VW       = smma_pkg::VALUE_W;
  localparam int unsigned PW       = smma_pkg::POS_W;
  localparam int unsigned IDX_W    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int unsigned TRI_SIZE = MAX_VARS * (MAX_VARS + 1) / 2;
  localparam int unsigned TRI_W    = (TRI_SIZE > 1) ? $clog2(TRI_SIZE) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_OBS + 1);
  localparam int unsigned PROD_W   = 2 * SAMPLE_BITS;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_ACC_A     = 7'b0000010,
    S_ACC_M     = 7'b0000100,
    S_ACC_S     = 7'b0001000,
    S_DIV_START = 7'b0010000,
    S_DIV_WAIT  = 7'b0100000,
    S_PUSH      = 7'b1000000
  } state_e;

  // Upper-triangle slot of entry (a, b)
  function automatic logic [TRI_W-1:0] tri_idx(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    logic [7:0]    base;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    base = (8'(lo) * (8'(2 * MAX_VARS + 1) - 8'(lo))) >> 1;
    return TRI_W'(base + 8'(hi - lo));
  endfunction

  state_e state_q, state_d;

  logic                           add_const_q;
  logic [smma_pkg::NV_W-1:0]      num_vars_q;
  logic signed [SAMPLE_BITS-1:0]  row_q    [MAX_VARS];
  logic signed [VW-1:0]           colsum_q [MAX_VARS];
  logic signed [VW-1:0]           psum_q   [TRI_SIZE];
  logic [CNT_W-1:0]               cnt_q;
  logic                           eos_q;
  logic [PW-1:0]                  i_q, j_q, r_q, c_q;
  logic signed [SAMPLE_BITS-1:0]  a_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [VW-1:0]           res_q;

  logic                           out_valid_q;
  logic [PW-1:0]                  out_row_q, out_col_q;
  logic signed [VW-1:0]           out_value_q;
  logic                           out_no_data_q, out_last_q;

  logic [smma_pkg::NV_W-1:0]      nv;
  logic [PW:0]                    size;
  logic [PW-1:0]                  size_m1;
  logic                           in_acc, vi_use, do_acc, empty;
  logic                           needs_div, push, entry_last;
  logic                           row_end, tri_end;
  logic [PW-1:0]                  row_rd_pos, col_rd_pos;
  logic [TRI_W-1:0]               tri_rd;
  logic signed [SAMPLE_BITS-1:0]  row_rd;
  logic signed [VW-1:0]           colsum_rd, psum_rd, div_dividend, div_quot;
  logic                           div_start;
  smma_pkg::div_status_t          div_st;

  // Effective variable count and matrix size
  always_comb begin
    nv = num_vars_q;
    if (nv == '0) nv = smma_pkg::NV_W'(1);
    if (nv > smma_pkg::NV_W'(MAX_VARS)) nv = smma_pkg::NV_W'(MAX_VARS);
    size    = {1'b0, nv} + {{PW{1'b0}}, add_const_q};
    size_m1 = PW'(size - 1'b1);
  end

  // Handshake and control decode
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign vi_use      = var_index_i < nv;
  assign do_acc      = vi_use && (var_index_i == nv - 1'b1) && (cnt_q < CNT_W'(MAX_OBS));
  assign empty       = (cnt_q == '0);
  assign needs_div   = !empty && ((r_q < nv) || (c_q < nv));
  assign push        = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);
  assign entry_last  = (r_q == size_m1) && (c_q == size_m1);
  assign row_end     = (j_q == nv - 1'b1);
  assign tri_end     = (i_q == nv - 1'b1);

  // Single read port for each store
  always_comb begin
    row_rd_pos = (state_q == S_ACC_A) ? i_q : j_q;
    col_rd_pos = (state_q == S_ACC_A) ? i_q : ((r_q < nv) ? r_q : c_q);
    tri_rd     = (state_q == S_ACC_S) ? tri_idx(i_q, j_q) : tri_idx(r_q, c_q);
    row_rd     = row_q[row_rd_pos[IDX_W-1:0]];
    colsum_rd  = colsum_q[col_rd_pos[IDX_W-1:0]];
    psum_rd    = psum_q[tri_rd];
    div_dividend = ((r_q < nv) && (c_q < nv)) ? psum_rd : colsum_rd;
  end

  assign div_start = (state_q == S_DIV_START) && needs_div;

  smma_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .quotient_o (div_quot),
    .status_o   (div_st)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (do_acc)            state_d = S_ACC_A;
          else if (end_of_set_i) state_d = S_DIV_START;
        end
      end
      S_ACC_A: state_d = S_ACC_M;
      S_ACC_M: state_d = S_ACC_S;
      S_ACC_S: begin
        if (!row_end)     state_d = S_ACC_M;
        else if (!tri_end) state_d = S_ACC_A;
        else if (eos_q)   state_d = S_DIV_START;
        else              state_d = S_IDLE;
      end
      S_DIV_START: state_d = needs_div ? S_DIV_WAIT : S_PUSH;
      S_DIV_WAIT: begin
        if (div_st.done) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (push) state_d = entry_last ? S_IDLE : S_DIV_START;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers, counters and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      add_const_q <= 1'b1;
      num_vars_q  <= smma_pkg::NV_W'(1);
      cnt_q       <= '0;
      eos_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      r_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < MAX_VARS; k++) begin
        row_q[k]    <= '0;
        colsum_q[k] <= '0;
      end
      for (int k = 0; k < TRI_SIZE; k++) begin
        psum_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;

      // take register writes
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          smma_pkg::CFG_ADD_CONST: add_const_q <= cfg_data_i[0];
          smma_pkg::CFG_NUM_VARS:  num_vars_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // buffer the sample and start a row update
      if (in_acc) begin
        eos_q <= end_of_set_i;
        i_q   <= '0;
        if (vi_use) row_q[var_index_i[IDX_W-1:0]] <= sample_i;
        if (do_acc) cnt_q <= cnt_q + 1'b1;
      end

      // column sum and start of a triangle row
      if (state_q == S_ACC_A) begin
        colsum_q[i_q[IDX_W-1:0]] <= smma_pkg::sat_add(colsum_rd, VW'(row_rd));
        j_q <= i_q;
      end

      // product sum and advance the walk
      if (state_q == S_ACC_S) begin
        psum_q[tri_rd] <= smma_pkg::sat_add(psum_rd, VW'(prod_q));
        if (row_end) i_q <= i_q + 1'b1;
        else         j_q <= j_q + 1'b1;
      end

      // output register
      if (push) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      // advance the matrix position; clear everything after the final item
      if (push) begin
        if (entry_last) begin
          r_q   <= '0;
          c_q   <= '0;
          cnt_q <= '0;
          for (int k = 0; k < MAX_VARS; k++) begin
            row_q[k]    <= '0;
            colsum_q[k] <= '0;
          end
          for (int k = 0; k < TRI_SIZE; k++) begin
            psum_q[k] <= '0;
          end
        end else if (c_q == size_m1) begin
          c_q <= '0;
          r_q <= r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_ACC_A) a_q <= row_rd;
    if (state_q == S_ACC_M) prod_q <= PROD_W'(a_q) * PROD_W'(row_rd);
    if ((state_q == S_DIV_START) && !needs_div) res_q <= empty ? VW'(0) : VW'(1);
    if ((state_q == S_DIV_WAIT) && div_st.done) res_q <= div_quot;
    if (push) begin
      out_row_q     <= r_q;
      out_col_q     <= c_q;
      out_value_q   <= res_q;
      out_no_data_q <= empty;
      out_last_q    <= entry_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_o       = out_row_q;
  assign col_o       = out_col_q;
  assign value_o     = out_value_q;
  assign no_data_o   = out_no_data_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  a_no_data_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_data_o |-> value_o == '0)
    else $error("no-data item carries a nonzero value");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && entry_last |=> cnt_q == '0 && state_q == S_IDLE)
    else $error("accumulators not cleared after final item");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_OBS))
    else $error("observation count beyond limit");

  a_div_only_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy || div_st.done |-> state_q == S_DIV_WAIT)
    else $error("divider active outside its wait state");

  a_pos_in_matrix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> r_q < size && c_q < size)
    else $error("matrix position beyond size");
`endif

endmodule

`default_nettype wire
